// ===== sv/double_ended_queue_engine_top_assert.svh =====
// Assertion macros for the double-ended queue engine.
// Expects clk and rst in scope at the point of use.
`ifndef DOUBLE_ENDED_QUEUE_ENGINE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication.
`define DQE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DQE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dqe_pkg.sv =====
// Shared types and codes for the double-ended queue engine.
// No dependencies.
package dqe_pkg;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_REMOVE     = 4'd4,
    OP_PEEK_BACK  = 4'd5,
    OP_CLEAR      = 4'd6,
    OP_SORT       = 4'd7,
    OP_VIEW_FWD   = 4'd8,
    OP_VIEW_BWD   = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NOMATCH = 3'd2,
    ST_FULL    = 3'd3,
    ST_FEW     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_REMOVE,
    S_SORT,
    S_SORT_END,
    S_VIEW_RD,
    S_VIEW_WT,
    S_FIN
  } state_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic    valid;
    status_t status;
    logic    last;
  } res_ctl_t;

endpackage

// ===== sv/dqe_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dqe_ctrl.sv =====
// Sequencer for the queue: ring pointers, scans for removal, sort and view.
// Depends on dqe_pkg; drives the entry RAM ports.
module dqe_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [3:0]                       in_op,
  input  logic [DATA_WIDTH-1:0]            in_val,
  input  logic                             out_free,
  output dqe_pkg::res_ctl_t                res,
  output logic [DATA_WIDTH-1:0]            res_value,
  output logic [$clog2(DEPTH+1)-1:0]       res_occ,
  output logic                             ram_we,
  output logic [$clog2(DEPTH)-1:0]         ram_waddr,
  output logic [DATA_WIDTH-1:0]            ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(DEPTH)-1:0]         ram_raddr,
  input  logic [DATA_WIDTH-1:0]            ram_rdata
);
  import dqe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_i, rd_i_next;
  logic [CW-1:0] pend_i, pend_i_next;
  logic [CW-1:0] wr_n, wr_n_next;
  logic          pend, pend_next;
  logic          swapped, swapped_next;
  logic          view_bwd, view_bwd_next;
  status_t       fin_st, fin_st_next;
  logic [DATA_WIDTH-1:0] opval, opval_next;
  logic [DATA_WIDTH-1:0] carry, carry_next;

  logic          accept;
  op_t           op;
  logic [CW-1:0] cnt_m1, pend_m1, view_pos, keep_n;
  logic          keep, issue;
  logic [AW-1:0] front_dec, front_inc;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, idx};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign op        = op_t'(in_op);
  assign cnt_m1    = count - 1'b1;
  assign pend_m1   = pend_i - 1'b1;
  assign view_pos  = view_bwd ? (cnt_m1 - rd_i) : rd_i;
  assign keep      = (ram_rdata != opval);
  assign keep_n    = wr_n + CW'(keep);
  assign issue     = (rd_i < count);
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_BACK:
              if (count != '0) state_next = S_RESP;
            OP_REMOVE:
              if (count != '0) state_next = S_REMOVE;
            OP_SORT:
              if (count >= CW'(2)) state_next = S_SORT;
            OP_VIEW_FWD, OP_VIEW_BWD:
              if (count != '0) state_next = S_VIEW_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RESP: if (out_free) state_next = S_IDLE;
      S_REMOVE: if (pend && pend_i == cnt_m1) state_next = S_FIN;
      S_SORT: if (pend && pend_i == cnt_m1) state_next = S_SORT_END;
      S_SORT_END: state_next = swapped ? S_SORT : S_FIN;
      S_VIEW_RD: state_next = S_VIEW_WT;
      S_VIEW_WT: begin
        if (out_free) begin
          state_next = (rd_i == cnt_m1) ? S_IDLE : S_VIEW_RD;
        end
      end
      S_FIN: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    front_next    = front;
    count_next    = count;
    rd_i_next     = rd_i;
    pend_i_next   = pend_i;
    wr_n_next     = wr_n;
    pend_next     = 1'b0;
    swapped_next  = swapped;
    view_bwd_next = view_bwd;
    fin_st_next   = fin_st;
    opval_next    = opval;
    carry_next    = carry;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    res           = '0;
    res_value     = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res.valid     = 1'b1;
          res.status    = ST_DONE;
          res.last      = 1'b1;
          rd_i_next     = '0;
          wr_n_next     = '0;
          swapped_next  = 1'b0;
          opval_next    = in_val;
          view_bwd_next = (op == OP_VIEW_BWD);
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count == CW'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_wdata  = in_val;
                count_next = count + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  front_next = front_dec;
                  ram_waddr  = front_dec;
                end else begin
                  ram_waddr = slot_of(front, count[AW-1:0]);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_BACK: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                res.valid = 1'b0;
                ram_re    = 1'b1;
                if (op == OP_POP_FRONT) begin
                  ram_raddr  = front;
                  front_next = front_inc;
                  count_next = cnt_m1;
                end else begin
                  ram_raddr = slot_of(front, cnt_m1[AW-1:0]);
                  if (op == OP_POP_BACK) count_next = cnt_m1;
                end
              end
            end
            OP_CLEAR: begin
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                count_next = '0;
                front_next = '0;
              end
            end
            OP_REMOVE, OP_VIEW_FWD, OP_VIEW_BWD: begin
              if (count == '0) res.status = ST_EMPTY;
              else res.valid = 1'b0;
            end
            OP_SORT: begin
              if (count < CW'(2)) res.status = ST_FEW;
              else res.valid = 1'b0;
            end
            default: res.status = ST_DONE;
          endcase
        end
      end

      S_RESP: begin
        if (out_free) begin
          res.valid  = 1'b1;
          res.status = ST_DONE;
          res.last   = 1'b1;
          res_value  = ram_rdata;
        end
      end

      S_REMOVE: begin
        if (issue) begin
          ram_re      = 1'b1;
          ram_raddr   = slot_of(front, rd_i[AW-1:0]);
          rd_i_next   = rd_i + 1'b1;
          pend_next   = 1'b1;
          pend_i_next = rd_i;
        end
        // Compaction: survivors are written down to the next free place.
        if (pend) begin
          if (keep) begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(front, wr_n[AW-1:0]);
            ram_wdata = ram_rdata;
          end
          wr_n_next = keep_n;
          if (pend_i == cnt_m1) begin
            count_next  = keep_n;
            fin_st_next = (keep_n == count) ? ST_NOMATCH : ST_DONE;
          end
        end
      end

      S_SORT: begin
        if (issue) begin
          ram_re      = 1'b1;
          ram_raddr   = slot_of(front, rd_i[AW-1:0]);
          rd_i_next   = rd_i + 1'b1;
          pend_next   = 1'b1;
          pend_i_next = rd_i;
        end
        // Bubble pass: carry the larger word forward, drop the smaller one behind.
        if (pend) begin
          if (pend_i == '0) begin
            carry_next = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = slot_of(front, pend_m1[AW-1:0]);
            if ($signed(carry) > $signed(ram_rdata)) begin
              ram_wdata    = ram_rdata;
              swapped_next = 1'b1;
            end else begin
              ram_wdata  = carry;
              carry_next = ram_rdata;
            end
          end
        end
      end

      S_SORT_END: begin
        ram_we       = 1'b1;
        ram_waddr    = slot_of(front, cnt_m1[AW-1:0]);
        ram_wdata    = carry;
        rd_i_next    = '0;
        swapped_next = 1'b0;
        fin_st_next  = ST_DONE;
      end

      S_VIEW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = slot_of(front, view_pos[AW-1:0]);
      end

      S_VIEW_WT: begin
        if (out_free) begin
          res.valid  = 1'b1;
          res.status = ST_DONE;
          res.last   = (rd_i == cnt_m1);
          res_value  = ram_rdata;
          rd_i_next  = rd_i + 1'b1;
        end
      end

      S_FIN: begin
        if (out_free) begin
          res.valid  = 1'b1;
          res.status = fin_st;
          res.last   = 1'b1;
        end
      end

      default: res = '0;
    endcase
  end

  assign res_occ = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_i     <= rd_i_next;
    pend_i   <= pend_i_next;
    wr_n     <= wr_n_next;
    swapped  <= swapped_next;
    view_bwd <= view_bwd_next;
    fin_st   <= fin_st_next;
    opval    <= opval_next;
    carry    <= carry_next;
  end

endmodule

// ===== sv/dqe_out.sv =====
// Output register holding one result until the downstream transfer.
// Depends on dqe_pkg.
module dqe_out #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dqe_pkg::res_ctl_t          res,
  input  logic [DATA_WIDTH-1:0]      res_value,
  input  logic [$clog2(DEPTH+1)-1:0] res_occ,
  output logic                       out_free,
  output logic                       valid,
  input  logic                       ready,
  output dqe_pkg::status_t           status,
  output logic [DATA_WIDTH-1:0]      value,
  output logic [$clog2(DEPTH+1)-1:0] occ,
  output logic                       last
);
  import dqe_pkg::*;

  assign out_free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status <= res.status;
      last   <= res.last;
      value  <= res_value;
      occ    <= res_occ;
    end
  end

endmodule

// ===== sv/double_ended_queue_engine_top.sv =====
// Push and clear: result registered in the cycle after the transfer, one item per cycle
// while the result side is not stalled. Pop, peek, removal, sort and view take no new op
// until done; pop and peek read the RAM, removal scans it once, compacting survivors.
// Sort: bubble passes over the RAM, at most count passes. View reads, then presents each.
// Reset clears front pointer, count and sequencer; the entry RAM is not cleared.
module double_ended_queue_engine_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_tdata,   // operand_value
  input  logic [3:0] s_tuser,                        // opcode
  output logic m_tvalid,
  input  logic m_tready,
  output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata, // result_value, occupancy
  output logic [2:0] m_tuser,                        // status
  output logic m_tlast                               // last_of_run
);
  import dqe_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int OUT_TW = ((DATA_WIDTH + CW + 7) / 8) * 8;

  res_ctl_t              res;
  logic [DATA_WIDTH-1:0] res_value, out_value;
  logic [CW-1:0]         res_occ, out_occ;
  logic                  out_free;
  status_t               out_status;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  dqe_ctrl #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_val    (s_tdata[DATA_WIDTH-1:0]),
    .out_free  (out_free),
    .res       (res),
    .res_value (res_value),
    .res_occ   (res_occ),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dqe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dqe_out #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_value (res_value),
    .res_occ   (res_occ),
    .out_free  (out_free),
    .valid     (m_tvalid),
    .ready     (m_tready),
    .status    (out_status),
    .value     (out_value),
    .occ       (out_occ),
    .last      (m_tlast)
  );

  assign m_tuser = out_status;
  assign m_tdata = OUT_TW'({out_occ, out_value});

`include "double_ended_queue_engine_top_assert.svh"

  `DQE_ASSERT_NOW(a_in_needs_room, s_tready, out_free, "transfer taken with output register busy")
  `DQE_ASSERT_NOW(a_res_needs_room, res.valid, out_free, "result produced with no room")
  `DQE_ASSERT_NEXT(a_res_lands, res.valid, m_tvalid, "produced result not presented")
  `DQE_ASSERT_NOW(a_occ_bound, m_tvalid, out_occ <= CW'(DEPTH), "occupancy beyond depth")
  `DQE_ASSERT_NOW(a_run_done, m_tvalid && !m_tlast, out_status == ST_DONE, "bad status mid-run")

endmodule
